[sv/rhct_pkg.sv]
package rhct_pkg;

  // Pipelined divider depth: one quotient bit per stage
  localparam int DIV_STEPS = 8;

  // Sector that holds the largest channel
  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  // Register map, word index
  typedef enum logic [2:0] {
    REG_CHANNEL_ORDER = 3'd0,
    REG_HUE_LOW       = 3'd1,
    REG_HUE_HIGH      = 3'd2,
    REG_LIGHT_LOW     = 3'd3,
    REG_LIGHT_HIGH    = 3'd4,
    REG_SAT_LOW       = 3'd5,
    REG_SAT_HIGH      = 3'd6
  } reg_idx_t;

  typedef logic signed [9:0] bound_t;

  localparam bound_t BOUND_MIN       = -10'sd256;
  localparam bound_t HUE_LOW_RST     = 10'sd75;
  localparam bound_t HUE_HIGH_RST    = 10'sd165;
  localparam bound_t LIGHT_LOW_RST   = 10'sd20;
  localparam bound_t LIGHT_HIGH_RST  = 10'sd220;
  localparam bound_t SAT_LOW_RST     = 10'sd100;
  localparam bound_t SAT_HIGH_RST    = 10'sd260;

  typedef struct packed {
    bound_t hue_low;
    bound_t hue_high;
    bound_t light_low;
    bound_t light_high;
    bound_t sat_low;
    bound_t sat_high;
  } bounds_t;

  // Data that rides alongside the divider
  typedef struct packed {
    logic       grey;
    logic [7:0] light;
    sector_t    sector;
    logic       neg;
  } side_t;

  // Divider word: {remainder, numerator bits / quotient bits}
  typedef struct packed {
    logic [15:0] w_sat;
    logic [15:0] w_hue;
    logic [7:0]  d_sat;
    logic [7:0]  d_hue;
    side_t       side;
  } div_word_t;

  typedef struct packed {
    logic [7:0] q_sat;
    logic [5:0] q_hue;
    side_t      side;
  } quot_t;

  // One restoring step; requires w[15:8] < d
  function automatic logic [15:0] div_step(input logic [15:0] w, input logic [7:0] d);
    logic [8:0]  t;
    logic [8:0]  r;
    logic [15:0] res;
    t = {w[15:8], w[7]};
    r = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      res = {r[7:0], w[6:0], 1'b1};
    end else begin
      res = {t[7:0], w[6:0], 1'b0};
    end
    return res;
  endfunction

  // Bound write: 10-bit two's complement, floored at -256
  function automatic bound_t sat_bound(input logic [9:0] bits);
    bound_t v;
    v = $signed(bits);
    if (v < BOUND_MIN) begin
      v = BOUND_MIN;
    end
    return v;
  endfunction

endpackage

[sv/rhct_front.sv]
module rhct_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  channel_order,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            first_byte,
  input  logic [7:0]            middle_byte,
  input  logic [7:0]            last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rhct_pkg::div_word_t   out_word
);
  import rhct_pkg::*;

  logic       s1_v_r;
  logic [7:0] r_r, g_r, b_r, mx_r, mn_r;
  logic [7:0] r_nxt, b_nxt, mx_nxt, mn_nxt;
  logic       s2_v_r;
  div_word_t  word_r, word_nxt;
  logic       s1_rdy, s2_rdy;

  // Stall chain
  assign s2_rdy   = !s2_v_r || out_ready;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Stage 1: channel order, max and min
  always_comb begin
    r_nxt  = channel_order ? first_byte : last_byte;
    b_nxt  = channel_order ? last_byte : first_byte;
    mx_nxt = r_nxt;
    mn_nxt = r_nxt;
    if (middle_byte > mx_nxt) mx_nxt = middle_byte;
    if (b_nxt > mx_nxt)       mx_nxt = b_nxt;
    if (middle_byte < mn_nxt) mn_nxt = middle_byte;
    if (b_nxt < mn_nxt)       mn_nxt = b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      r_r  <= r_nxt;
      g_r  <= middle_byte;
      b_r  <= b_nxt;
      mx_r <= mx_nxt;
      mn_r <= mn_nxt;
    end
  end

  // Stage 2: diff, sum, divisors and numerators
  always_comb begin
    logic [7:0] diff;
    logic [8:0] sum;
    logic [8:0] den_hi;
    logic [7:0] pa, pb, mag;
    logic [15:0] m16;
    diff   = mx_r - mn_r;
    sum    = {1'b0, mx_r} + {1'b0, mn_r};
    den_hi = 9'd510 - sum;
    word_nxt = '0;
    if (mx_r == r_r) begin
      word_nxt.side.sector = SEC_RED;
      pa = g_r;
      pb = b_r;
    end else if (mx_r == g_r) begin
      word_nxt.side.sector = SEC_GREEN;
      pa = b_r;
      pb = r_r;
    end else begin
      word_nxt.side.sector = SEC_BLUE;
      pa = r_r;
      pb = g_r;
    end
    mag = (pa < pb) ? (pb - pa) : (pa - pb);
    m16 = {8'd0, mag};
    word_nxt.side.neg   = pa < pb;
    word_nxt.side.grey  = diff == 8'd0;
    word_nxt.side.light = sum[8:1];
    word_nxt.d_sat      = (sum <= 9'd255) ? sum[7:0] : den_hi[7:0];
    word_nxt.d_hue      = diff;
    // 255*diff and 60*|x|
    word_nxt.w_sat      = {diff, 8'd0} - {8'd0, diff};
    word_nxt.w_hue      = (m16 << 6) - (m16 << 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_word  = word_r;

endmodule

[sv/rhct_div.sv]
module rhct_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rhct_pkg::div_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rhct_pkg::quot_t       out_quot
);
  import rhct_pkg::*;

  div_word_t              stg_r   [DIV_STEPS];
  div_word_t              stg_nxt [DIV_STEPS];
  logic [DIV_STEPS-1:0]   v_r;
  logic [DIV_STEPS:0]     rdy;

  assign rdy[DIV_STEPS] = out_ready;
  assign in_ready       = rdy[0];

  // One quotient bit per stage for both divisions
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    div_word_t src;
    logic      src_v;
    if (k == 0) begin : g_first
      assign src   = in_word;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = stg_r[k-1];
      assign src_v = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    always_comb begin
      stg_nxt[k]       = src;
      stg_nxt[k].w_sat = div_step(src.w_sat, src.d_sat);
      stg_nxt[k].w_hue = div_step(src.w_hue, src.d_hue);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid      = v_r[DIV_STEPS-1];
  assign out_quot.q_sat = stg_r[DIV_STEPS-1].w_sat[7:0];
  assign out_quot.q_hue = stg_r[DIV_STEPS-1].w_hue[5:0];
  assign out_quot.side  = stg_r[DIV_STEPS-1].side;

endmodule

[sv/rhct_back.sv]
module rhct_back (
  input  logic                clk,
  input  logic                rst_n,
  input  rhct_pkg::bounds_t   bounds,
  input  logic                in_valid,
  output logic                in_ready,
  input  rhct_pkg::quot_t     in_quot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          hue,
  output logic [7:0]          lightness,
  output logic [7:0]          saturation,
  output logic                within_bounds
);
  import rhct_pkg::*;

  logic       b1_v_r, b2_v_r, b3_v_r;
  logic       b1_rdy, b2_rdy, b3_rdy;
  logic [9:0] t_r, t_nxt;
  logic       grey_r;
  logic [7:0] sat1_r, light1_r;
  logic [7:0] hue2_r, hue2_nxt, sat2_r, light2_r;
  logic [7:0] hue_r, light_r, sat_r;
  logic       ok_r, ok_nxt;

  assign b3_rdy   = !b3_v_r || out_ready;
  assign b2_rdy   = !b2_v_r || b3_rdy;
  assign b1_rdy   = !b1_v_r || b2_rdy;
  assign in_ready = b1_rdy;

  // Stage 1: degrees by sector, then (17*deg + 12) >> 3
  always_comb begin
    logic [8:0]  deg;
    logic [8:0]  q9;
    logic [12:0] m;
    q9 = {3'd0, in_quot.q_hue};
    case (in_quot.side.sector)
      SEC_RED:   deg = in_quot.side.neg ? (9'd360 - q9) : q9;
      SEC_GREEN: deg = in_quot.side.neg ? (9'd120 - q9) : (9'd120 + q9);
      SEC_BLUE:  deg = in_quot.side.neg ? (9'd240 - q9) : (9'd240 + q9);
      default:   deg = 9'd0;
    endcase
    m     = {deg, 4'd0} + {4'd0, deg} + 13'd12;
    t_nxt = m[12:3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (b1_rdy) begin
      b1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_rdy) begin
      t_r      <= t_nxt;
      grey_r   <= in_quot.side.grey;
      sat1_r   <= in_quot.side.grey ? 8'd0 : in_quot.q_sat;
      light1_r <= in_quot.side.light;
    end
  end

  // Stage 2: divide by 3 as multiply by 683 and shift by 11
  always_comb begin
    logic [19:0] prod;
    prod = {10'd0, t_r} * 20'd683;
    if (grey_r) begin
      hue2_nxt = 8'd0;
    end else if (prod[19]) begin
      hue2_nxt = 8'd255;
    end else begin
      hue2_nxt = prod[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (b2_rdy) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b2_rdy) begin
      hue2_r   <= hue2_nxt;
      sat2_r   <= sat1_r;
      light2_r <= light1_r;
    end
  end

  // Stage 3: bound check into the output register
  always_comb begin
    bound_t h, l, s;
    h = $signed({2'b00, hue2_r});
    l = $signed({2'b00, light2_r});
    s = $signed({2'b00, sat2_r});
    ok_nxt = (h >= bounds.hue_low)   && (h <= bounds.hue_high) &&
             (l >= bounds.light_low) && (l <= bounds.light_high) &&
             (s >= bounds.sat_low)   && (s <= bounds.sat_high);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (b3_rdy) begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b3_rdy) begin
      hue_r   <= hue2_r;
      light_r <= light2_r;
      sat_r   <= sat2_r;
      ok_r    <= ok_nxt;
    end
  end

  assign out_valid     = b3_v_r;
  assign hue           = hue_r;
  assign lightness     = light_r;
  assign saturation    = sat_r;
  assign within_bounds = ok_r;

endmodule

[sv/rgb_to_hls_color_threshold.sv]
// Pipeline: 2 front, 8 divider, 3 back stages from an accepted pixel to out_tvalid.
// Throughput: one pixel per cycle while out_tready is high; every stage has its own valid
// bit, so bubbles are squeezed out while the output is stalled and a stall loses nothing.
// One pixel per cycle holds because the divider is unrolled into 8 stages of one quotient bit.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module rgb_to_hls_color_threshold (
  input  logic        clk,
  input  logic        rst_n,
  // pixel request in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] first_byte, [15:8] middle_byte, [23:16] last_byte
  // result out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] hue, [15:8] lightness, [23:16] saturation
  output logic        out_tuser,  // [0] within_bounds
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rhct_pkg::*;

  logic      channel_order_r;
  bounds_t   bounds_r;
  logic      cfg_we;
  reg_idx_t  cfg_idx;

  logic      f_valid, f_ready;
  div_word_t f_word;
  logic      d_valid, d_ready;
  quot_t     d_quot;

  logic [7:0] hue, lightness, saturation;
  logic       within_bounds;

  // Register port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_order_r     <= 1'b0;
      bounds_r.hue_low    <= HUE_LOW_RST;
      bounds_r.hue_high   <= HUE_HIGH_RST;
      bounds_r.light_low  <= LIGHT_LOW_RST;
      bounds_r.light_high <= LIGHT_HIGH_RST;
      bounds_r.sat_low    <= SAT_LOW_RST;
      bounds_r.sat_high   <= SAT_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CHANNEL_ORDER: channel_order_r     <= pwdata[0];
        REG_HUE_LOW:       bounds_r.hue_low    <= sat_bound(pwdata[9:0]);
        REG_HUE_HIGH:      bounds_r.hue_high   <= sat_bound(pwdata[9:0]);
        REG_LIGHT_LOW:     bounds_r.light_low  <= sat_bound(pwdata[9:0]);
        REG_LIGHT_HIGH:    bounds_r.light_high <= sat_bound(pwdata[9:0]);
        REG_SAT_LOW:       bounds_r.sat_low    <= sat_bound(pwdata[9:0]);
        REG_SAT_HIGH:      bounds_r.sat_high   <= sat_bound(pwdata[9:0]);
        default: ;
      endcase
    end
  end

  // Read back, bounds sign-extended
  always_comb begin
    case (cfg_idx)
      REG_CHANNEL_ORDER: prdata = {31'd0, channel_order_r};
      REG_HUE_LOW:       prdata = {{22{bounds_r.hue_low[9]}}, bounds_r.hue_low};
      REG_HUE_HIGH:      prdata = {{22{bounds_r.hue_high[9]}}, bounds_r.hue_high};
      REG_LIGHT_LOW:     prdata = {{22{bounds_r.light_low[9]}}, bounds_r.light_low};
      REG_LIGHT_HIGH:    prdata = {{22{bounds_r.light_high[9]}}, bounds_r.light_high};
      REG_SAT_LOW:       prdata = {{22{bounds_r.sat_low[9]}}, bounds_r.sat_low};
      REG_SAT_HIGH:      prdata = {{22{bounds_r.sat_high[9]}}, bounds_r.sat_high};
      default:           prdata = 32'd0;
    endcase
  end

  rhct_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .channel_order (channel_order_r),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .first_byte    (in_tdata[7:0]),
    .middle_byte   (in_tdata[15:8]),
    .last_byte     (in_tdata[23:16]),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_word      (f_word)
  );

  rhct_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_quot  (d_quot)
  );

  rhct_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .bounds        (bounds_r),
    .in_valid      (d_valid),
    .in_ready      (d_ready),
    .in_quot       (d_quot),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .hue           (hue),
    .lightness     (lightness),
    .saturation    (saturation),
    .within_bounds (within_bounds)
  );

  assign out_tdata = {saturation, lightness, hue};
  assign out_tuser = within_bounds;

  // Zero saturation only comes from a grey pixel, which also has zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[23:16] == 8'd0) |-> (out_tdata[7:0] == 8'd0))
    else $error("saturation zero with nonzero hue");

  // Input only backs up when the whole pipeline is full and the output is held
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled while output is free");

  // Stored bounds never fall below -256
  a_bound_floor: assert property (@(posedge clk) disable iff (!rst_n)
    !(bounds_r.hue_low[9]   && !bounds_r.hue_low[8])   &&
    !(bounds_r.hue_high[9]  && !bounds_r.hue_high[8])  &&
    !(bounds_r.light_low[9] && !bounds_r.light_low[8]) &&
    !(bounds_r.light_high[9] && !bounds_r.light_high[8]) &&
    !(bounds_r.sat_low[9]   && !bounds_r.sat_low[8])   &&
    !(bounds_r.sat_high[9]  && !bounds_r.sat_high[8]))
    else $error("bound register below floor");

endmodule

[dv/tb_rgb_to_hls_color_threshold.sv]
module tb_rgb_to_hls_color_threshold;
  import rhct_pkg::*;

  localparam int PIPE_LATENCY = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int UNUSED_REG   = 7;

  // Expected HLS result of one pixel
  typedef struct {
    logic [7:0] hue;
    logic [7:0] light;
    logic [7:0] sat;
    logic       within_bounds;
  } hls_result_t;

  // Scoreboard: own copy of the registers, HLS predictor, queue of expected results
  class hls_scoreboard;
    logic        order_rgb;
    int          bnd_lo[3];
    int          bnd_hi[3];
    hls_result_t hls_expected_q[$];
    int          fail_count;

    function new();
      fail_count = 0;
      order_rgb  = 1'b0;
      bnd_lo[0] = 75;  bnd_hi[0] = 165;
      bnd_lo[1] = 20;  bnd_hi[1] = 220;
      bnd_lo[2] = 100; bnd_hi[2] = 260;
    endfunction

    // Low 10 bits, two's complement, floored at -256
    function int decode_bound(logic [31:0] value);
      logic signed [9:0] s;
      int b;
      s = value[9:0];
      b = int'(s);
      if (b < -256) b = -256;
      return b;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      case (idx)
        REG_CHANNEL_ORDER: order_rgb = value[0];
        REG_HUE_LOW:       bnd_lo[0] = decode_bound(value);
        REG_HUE_HIGH:      bnd_hi[0] = decode_bound(value);
        REG_LIGHT_LOW:     bnd_lo[1] = decode_bound(value);
        REG_LIGHT_HIGH:    bnd_hi[1] = decode_bound(value);
        REG_SAT_LOW:       bnd_lo[2] = decode_bound(value);
        REG_SAT_HIGH:      bnd_hi[2] = decode_bound(value);
        default: ;
      endcase
    endfunction

    // Accepted pixel: work out hue, lightness, saturation and the range flag
    function void note_pixel(logic [23:0] px);
      int r, g, b, mx, mn, diff, sum, light, hue, sat, deg;
      hls_result_t res;
      g = int'(px[15:8]);
      r = order_rgb ? int'(px[7:0]) : int'(px[23:16]);
      b = order_rgb ? int'(px[23:16]) : int'(px[7:0]);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      diff  = mx - mn;
      sum   = mx + mn;
      light = sum >>> 1;
      hue   = 0;
      sat   = 0;
      if (diff != 0) begin
        sat = (sum <= 255) ? (255 * diff) / sum : (255 * diff) / (510 - sum);
        // sector by max channel, ties to red then green; division truncates
        if (mx == r) deg = (60 * (g - b)) / diff + ((g < b) ? 360 : 0);
        else if (mx == g) deg = (60 * (b - r)) / diff + 120;
        else deg = (60 * (r - g)) / diff + 240;
        hue = (deg * 255 + 180) / 360;
        if (hue < 0) hue = 0;
        if (hue > 255) hue = 255;
      end
      res.hue           = hue[7:0];
      res.light         = light[7:0];
      res.sat           = sat[7:0];
      res.within_bounds = (hue >= bnd_lo[0]) && (hue <= bnd_hi[0]) &&
                          (light >= bnd_lo[1]) && (light <= bnd_hi[1]) &&
                          (sat >= bnd_lo[2]) && (sat <= bnd_hi[2]);
      hls_expected_q = {hls_expected_q, res};
    endfunction

    function void check_result(logic [23:0] data, logic flag);
      hls_result_t exp_res;
      if (hls_expected_q.size() == 0) begin
        $error("result with nothing expected: tdata %h tuser %b", data, flag);
        fail_count++;
        return;
      end
      exp_res = hls_expected_q.pop_front();
      if (data[7:0] !== exp_res.hue) begin
        $error("hue expected %0d got %0d", exp_res.hue, data[7:0]);
        fail_count++;
      end
      if (data[15:8] !== exp_res.light) begin
        $error("lightness expected %0d got %0d", exp_res.light, data[15:8]);
        fail_count++;
      end
      if (data[23:16] !== exp_res.sat) begin
        $error("saturation expected %0d got %0d", exp_res.sat, data[23:16]);
        fail_count++;
      end
      if (flag !== exp_res.within_bounds) begin
        $error("within_bounds expected %0d got %0d", exp_res.within_bounds, flag);
        fail_count++;
      end
    endfunction

    function int pending();
      return hls_expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  hls_scoreboard sb;
  bit            sender_idle;
  bit            receiver_idle;
  bit            hold_long;

  rgb_to_hls_color_threshold uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && sb != null && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser);
    end
  end

  // Result side: random stall bursts, one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_long = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run limit
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  // All driving tasks start and end at a falling edge
  task automatic send_pixel(input logic [23:0] px);
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(px);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (sender_idle && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (PIPE_LATENCY + 3) @(negedge clk);
  endtask

  task automatic apb_write(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // 10-bit bound with junk in the unused upper bits
  function automatic logic [31:0] bound_word(input int v);
    logic [31:0] junk;
    junk = $urandom;
    return {junk[31:10], 10'(v)};
  endfunction

  function automatic logic [23:0] rand_pixel();
    logic [7:0] px[3];
    int v, k, t;
    case ($urandom_range(0, 9))
      0: begin
        v = $urandom_range(0, 255);
        px[0] = 8'(v); px[1] = 8'(v); px[2] = 8'(v);
      end
      1, 2: begin
        // two channels equal: sector ties
        v = $urandom_range(0, 255);
        k = $urandom_range(0, 2);
        px[0] = 8'(v); px[1] = 8'(v); px[2] = 8'(v);
        px[k] = 8'($urandom_range(0, 255));
      end
      3: begin
        // nearly grey
        v = $urandom_range(0, 255);
        for (int i = 0; i < 3; i++) begin
          t = v + $urandom_range(0, 6) - 3;
          if (t < 0) t = 0;
          if (t > 255) t = 255;
          px[i] = 8'(t);
        end
      end
      4: begin
        for (int i = 0; i < 3; i++) px[i] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      default: begin
        for (int i = 0; i < 3; i++) px[i] = 8'($urandom_range(0, 255));
      end
    endcase
    return {px[2], px[1], px[0]};
  endfunction

  // Main sequence
  initial begin
    logic [23:0] directed_px[$];
    int lo, hi;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_long     = 1'b0;
    sb = new();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed pixels under reset registers, packed {last, middle, first}
    directed_px = '{
      24'h000000, 24'hFFFFFF, 24'h808080,  // grey
      24'hFF0000, 24'h00FF00, 24'h0000FF,  // pure channels
      24'hFF0001,                          // red max, g < b: 360 degrees
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF,  // two-way ties
      24'hC83764, 24'hC83864,              // sum 255 and 256
      24'h656464, 24'h000001, 24'hFEFFFF,
      24'h0A0009, 24'h1E7850, 24'h50C8A0
    };
    foreach (directed_px[i]) begin
      send_pixel(directed_px[i]);
      sender_gap();
    end
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      apb_write(REG_CHANNEL_ORDER, {16'($urandom_range(0, 65535)), 15'd0, 1'(p % 2)});
      for (int i = 0; i < 3; i++) begin
        case (p)
          0: begin lo = -256; hi = 511; end   // wide open
          1: begin lo = 511;  hi = -256; end  // closed
          2: begin lo = 512;  hi = 511; end   // -512 floors to -256
          default: begin
            lo = $urandom_range(0, 180) - 20;
            hi = lo + $urandom_range(30, 300);
          end
        endcase
        apb_write(int'(REG_HUE_LOW) + 2 * i,
                  ($urandom_range(0, 4) == 0) ? $urandom : bound_word(lo));
        apb_write(int'(REG_HUE_HIGH) + 2 * i,
                  ($urandom_range(0, 4) == 0) ? $urandom : bound_word(hi));
      end
      if (p == 2) begin
        // exact extremes of the bound encoding
        apb_write(REG_HUE_LOW, 32'h0000_0200);
        apb_write(REG_HUE_HIGH, 32'hFFFF_FDFF);
        apb_write(REG_SAT_HIGH, 32'h0000_01FF);
      end
      apb_write(UNUSED_REG, $urandom);

      sender_idle   = (p != 5) && (p != PHASES - 1);
      receiver_idle = (p != PHASES - 1);
      if (p == 5) hold_long = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel(rand_pixel());
        sender_gap();
        if (p == 4 && n == PHASE_ITEMS / 2) begin
          in_tvalid <= 1'b0;
          while (sb.pending() != 0) @(negedge clk);
        end
      end
      wait_drained();
    end

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
